// ----- hdl/tdec_pkg.sv -----
// Shared widths, codes and types for the top decay event classifier.
package tdec_pkg;

    localparam int CODE_W     = 24;
    localparam int ENERGY_W   = 23;
    localparam int MOM_W      = 24;
    localparam int DECAY_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    localparam int FERMIONS_PER_EVENT = 6;
    localparam int JET_SLOTS          = 4;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_MASS_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASS_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WANTED_TYPE = 2'd2;

    localparam logic [CFG_DATA_W-1:0] MASS_LOW_RESET  = 23'd166160;
    localparam logic [CFG_DATA_W-1:0] MASS_HIGH_RESET = 23'd180260;
    localparam logic [DECAY_W-1:0]    WANTED_RESET    = 3'd2;

    // decay classes
    localparam logic [DECAY_W-1:0] DECAY_NONE     = 3'd0;
    localparam logic [DECAY_W-1:0] DECAY_HADRONIC = 3'd1;
    localparam logic [DECAY_W-1:0] DECAY_BOTH     = 3'd2;
    localparam logic [DECAY_W-1:0] DECAY_LEPTONIC = 3'd3;
    localparam logic [DECAY_W-1:0] DECAY_TAU      = 3'd4;

    // particle code magnitudes
    localparam logic [CODE_W-1:0] CODE_QUARK_MAX = 24'd5;
    localparam logic [CODE_W-1:0] CODE_ELECTRON  = 24'd11;
    localparam logic [CODE_W-1:0] CODE_NU_E      = 24'd12;
    localparam logic [CODE_W-1:0] CODE_MUON      = 24'd13;
    localparam logic [CODE_W-1:0] CODE_NU_MU     = 24'd14;
    localparam logic [CODE_W-1:0] CODE_TAU       = 24'd15;
    localparam logic [CODE_W-1:0] CODE_NU_TAU    = 24'd16;

    typedef struct packed {
        logic        [ENERGY_W-1:0] energy;
        logic signed [MOM_W-1:0]    px;
        logic signed [MOM_W-1:0]    py;
        logic signed [MOM_W-1:0]    pz;
    } fourvec_t;

endpackage

// ----- hdl/tdec_ifs.sv -----
// Item channels: fermion input and classification result.
interface tdec_fermion_if;
    import tdec_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [CODE_W-1:0] particle_code;
    logic [ENERGY_W-1:0]      energy_mev;
    logic signed [MOM_W-1:0]  mom_x_mev;
    logic signed [MOM_W-1:0]  mom_y_mev;
    logic signed [MOM_W-1:0]  mom_z_mev;
    logic                     last_fermion;

    modport source (output valid, particle_code, energy_mev, mom_x_mev, mom_y_mev,
                    mom_z_mev, last_fermion, input ready);
    modport sink   (input valid, particle_code, energy_mev, mom_x_mev, mom_y_mev,
                    mom_z_mev, last_fermion, output ready);
endinterface

interface tdec_result_if;
    import tdec_pkg::*;

    logic               valid;
    logic               ready;
    logic [DECAY_W-1:0] decay_type;
    logic               passed;
    logic               count_mismatch;

    modport source (output valid, decay_type, passed, count_mismatch, input ready);
    modport sink   (input valid, decay_type, passed, count_mismatch, output ready);
endinterface

// ----- hdl/top_decay_event_classifier.sv -----
// Top decay event classifier: sorts six fermions, then tests top mass hypotheses.
//
// Fermions arrive one item per cycle while the block collects; an item that does not
// end the event is taken and the block is ready again at once. The item marked last
// takes longer: the counts are checked (a count mismatch then goes straight to the
// result), the window bounds are squared, the invariant-mass evaluations are run and
// the result is posted. Between two and eight evaluations are run. All squares go
// through a single registered 25x25 squarer fed by a small sequencer. Input is not
// accepted during the evaluation; a posted result may wait in its output register
// while the next event is collected.
module top_decay_event_classifier (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tdec_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tdec_pkg::CFG_DATA_W-1:0]      cfg_data,
    tdec_fermion_if.sink                         fermion,
    tdec_result_if.source                        result
);
    import tdec_pkg::*;

    localparam logic [2:0] S_COLLECT = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_BOUNDS  = 3'd2;
    localparam logic [2:0] S_EVAL    = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    localparam logic [1:0] MODE_LEP     = 2'd0;
    localparam logic [1:0] MODE_HAD_ONE = 2'd1;
    localparam logic [1:0] MODE_HAD_ALL = 2'd2;

    localparam logic [2:0] STEP_CMP = 3'd6;
    localparam logic [1:0] IDX_LAST = 2'(JET_SLOTS - 1);
    localparam logic [2:0] CNT_MAX  = 3'd7;

    function automatic logic [2:0] sat_inc(input logic [2:0] c);
        sat_inc = (c == CNT_MAX) ? CNT_MAX : c + 3'd1;
    endfunction

    // one component of a four-vector, widened for three-way and four-way sums
    function automatic logic signed [26:0] comp(input fourvec_t v, input logic [1:0] c);
        case (c)
            2'd0:    comp = $signed({4'b0, v.energy});
            2'd1:    comp = 27'(v.px);
            2'd2:    comp = 27'(v.py);
            default: comp = 27'(v.pz);
        endcase
    endfunction

    // control
    logic [2:0]            state_reg, state_next;
    logic [2:0]            step_reg, step_next;
    logic [1:0]            mode_reg, mode_next;
    logic [1:0]            idx_reg, idx_next;
    logic                  lept_reg, lept_next;
    logic                  hadr_reg, hadr_next;
    logic                  mismatch_reg, mismatch_next;
    logic [2:0]            jet_count_reg, jet_count_next;
    logic [2:0]            lep_count_reg, lep_count_next;
    logic [2:0]            nu_count_reg, nu_count_next;
    logic [2:0]            tau_count_reg, tau_count_next;
    logic [2:0]            item_count_reg, item_count_next;
    logic                  out_valid_reg, out_valid_next;
    logic [ENERGY_W-1:0]   mass_low_reg, mass_high_reg;
    logic [DECAY_W-1:0]    wanted_reg;

    // data path
    fourvec_t              jet_reg [JET_SLOTS];
    fourvec_t              lep_reg;
    fourvec_t              nu_reg;
    logic [24:0]           sum_reg, sum_next;
    logic [49:0]           prod_reg;
    logic signed [52:0]    acc_reg, acc_next;
    logic [45:0]           lo2_reg, hi2_reg;
    logic [DECAY_W-1:0]    decay_reg, decay_next;
    logic                  passed_reg;
    logic                  cmis_reg;

    fourvec_t              in_vec;
    logic [CODE_W-1:0]     mag;
    logic                  is_jet, is_nu, is_lep, is_tau;
    logic                  take, classify, post;
    logic signed [26:0]    sel_comp, jets_sum, tri_sum;
    logic                  in_win;

    assign fermion.ready = (state_reg == S_COLLECT);
    assign take          = fermion.valid && fermion.ready;
    assign classify      = take && (item_count_reg < 3'(FERMIONS_PER_EVENT));
    assign post          = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    assign in_vec = '{energy: fermion.energy_mev, px: fermion.mom_x_mev,
                      py: fermion.mom_y_mev, pz: fermion.mom_z_mev};

    always_comb
    begin
        mag    = fermion.particle_code[CODE_W-1] ? -fermion.particle_code
                                                 : fermion.particle_code;
        is_jet = mag inside {[24'd1:CODE_QUARK_MAX]};
        is_nu  = mag inside {CODE_NU_E, CODE_NU_MU, CODE_NU_TAU};
        is_lep = mag inside {CODE_ELECTRON, CODE_MUON, CODE_TAU};
        is_tau = (mag == CODE_TAU);
    end

    // summed component for the current hypothesis; a jet triple is all four less one
    always_comb
    begin
        sel_comp = comp(jet_reg[idx_reg], step_reg[1:0]);
        jets_sum = comp(jet_reg[0], step_reg[1:0]) + comp(jet_reg[1], step_reg[1:0])
                 + comp(jet_reg[2], step_reg[1:0]) + comp(jet_reg[3], step_reg[1:0]);
        if (mode_reg == MODE_LEP)
            tri_sum = comp(lep_reg, step_reg[1:0]) + comp(nu_reg, step_reg[1:0]) + sel_comp;
        else
            tri_sum = jets_sum - sel_comp;
    end

    assign in_win = (acc_reg > $signed({7'b0, lo2_reg})) && (acc_reg < $signed({7'b0, hi2_reg}));

    always_comb
    begin
        sum_next = tri_sum[26] ? 25'(-tri_sum) : tri_sum[24:0];
        if (state_reg == S_BOUNDS)
            sum_next = (step_reg == 3'd0) ? {2'b0, mass_low_reg} : {2'b0, mass_high_reg};
    end

    always_comb
    begin
        acc_next = acc_reg - $signed({3'b0, prod_reg});
        if (step_reg == 3'd2)
            acc_next = $signed({3'b0, prod_reg});
    end

    always_comb
    begin
        decay_next = DECAY_NONE;
        if (lept_reg && hadr_reg)
            decay_next = DECAY_BOTH;
        else if (lept_reg)
            decay_next = DECAY_LEPTONIC;
        else if (hadr_reg)
            decay_next = DECAY_HADRONIC;
        if (decay_next != DECAY_NONE && tau_count_reg != 3'd0)
            decay_next = DECAY_TAU;
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        mode_next       = mode_reg;
        idx_next        = idx_reg;
        lept_next       = lept_reg;
        hadr_next       = hadr_reg;
        mismatch_next   = mismatch_reg;
        jet_count_next  = jet_count_reg;
        lep_count_next  = lep_count_reg;
        nu_count_next   = nu_count_reg;
        tau_count_next  = tau_count_reg;
        item_count_next = item_count_reg;
        out_valid_next  = out_valid_reg && !result.ready;

        case (state_reg)
            S_COLLECT:
            begin
                if (take)
                begin
                    item_count_next = sat_inc(item_count_reg);
                    if (classify && is_jet)
                        jet_count_next = sat_inc(jet_count_reg);
                    if (classify && is_nu)
                        nu_count_next = sat_inc(nu_count_reg);
                    if (classify && is_lep)
                        lep_count_next = sat_inc(lep_count_reg);
                    if (classify && is_tau)
                        tau_count_next = sat_inc(tau_count_reg);
                    if (fermion.last_fermion)
                        state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                lept_next     = 1'b0;
                hadr_next     = 1'b0;
                mismatch_next = !(lep_count_reg == 3'd1 && nu_count_reg == 3'd1
                                  && jet_count_reg == 3'(JET_SLOTS));
                step_next     = 3'd0;
                state_next    = mismatch_next ? S_DONE : S_BOUNDS;
            end
            S_BOUNDS:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3)
                begin
                    state_next = S_EVAL;
                    step_next  = 3'd0;
                    mode_next  = MODE_LEP;
                    idx_next   = 2'd0;
                end
            end
            S_EVAL:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_CMP)
                begin
                    step_next = 3'd0;
                    case (mode_reg)
                        MODE_LEP:
                        begin
                            if (in_win)
                            begin
                                // leptonic top found: test the other three jets once
                                lept_next = 1'b1;
                                mode_next = MODE_HAD_ONE;
                            end
                            else if (idx_reg == IDX_LAST)
                            begin
                                mode_next = MODE_HAD_ALL;
                                idx_next  = 2'd0;
                            end
                            else
                                idx_next = idx_reg + 2'd1;
                        end
                        MODE_HAD_ONE:
                        begin
                            hadr_next  = in_win;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            hadr_next = in_win;
                            if (in_win || idx_reg == IDX_LAST)
                                state_next = S_DONE;
                            else
                                idx_next = idx_reg + 2'd1;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (post)
                begin
                    out_valid_next  = 1'b1;
                    jet_count_next  = 3'd0;
                    lep_count_next  = 3'd0;
                    nu_count_next   = 3'd0;
                    tau_count_next  = 3'd0;
                    item_count_next = 3'd0;
                    state_next      = S_COLLECT;
                end
            end
            default:
                state_next = S_COLLECT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_COLLECT;
            step_reg       <= 3'd0;
            mode_reg       <= MODE_LEP;
            idx_reg        <= 2'd0;
            lept_reg       <= 1'b0;
            hadr_reg       <= 1'b0;
            mismatch_reg   <= 1'b0;
            jet_count_reg  <= 3'd0;
            lep_count_reg  <= 3'd0;
            nu_count_reg   <= 3'd0;
            tau_count_reg  <= 3'd0;
            item_count_reg <= 3'd0;
            out_valid_reg  <= 1'b0;
            mass_low_reg   <= MASS_LOW_RESET;
            mass_high_reg  <= MASS_HIGH_RESET;
            wanted_reg     <= WANTED_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            mode_reg       <= mode_next;
            idx_reg        <= idx_next;
            lept_reg       <= lept_next;
            hadr_reg       <= hadr_next;
            mismatch_reg   <= mismatch_next;
            jet_count_reg  <= jet_count_next;
            lep_count_reg  <= lep_count_next;
            nu_count_reg   <= nu_count_next;
            tau_count_reg  <= tau_count_next;
            item_count_reg <= item_count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MASS_LOW:    mass_low_reg  <= cfg_data;
                    REG_MASS_HIGH:   mass_high_reg <= cfg_data;
                    REG_WANTED_TYPE: wanted_reg    <= cfg_data[DECAY_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (classify && is_jet && jet_count_reg < 3'(JET_SLOTS))
            jet_reg[jet_count_reg[1:0]] <= in_vec;
        if (classify && is_nu)
            nu_reg <= in_vec;
        if (classify && is_lep)
            lep_reg <= in_vec;

        sum_reg  <= sum_next;
        prod_reg <= sum_reg * sum_reg;
        acc_reg  <= acc_next;
        if (state_reg == S_BOUNDS && step_reg == 3'd2)
            lo2_reg <= prod_reg[45:0];
        if (state_reg == S_BOUNDS && step_reg == 3'd3)
            hi2_reg <= prod_reg[45:0];

        if (post)
        begin
            decay_reg  <= decay_next;
            passed_reg <= (decay_next == wanted_reg);
            cmis_reg   <= mismatch_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.decay_type     = decay_reg;
    assign result.passed         = passed_reg;
    assign result.count_mismatch = cmis_reg;

    a_mismatch_no_type: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.count_mismatch) |-> (result.decay_type == DECAY_NONE))
        else $error("count mismatch posted with a decay type");

    a_passed_matches: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.passed == (result.decay_type == wanted_reg)))
        else $error("pass flag disagrees with wanted type");

    a_last_starts_check: assert property (@(posedge clk) disable iff (!rst_n)
        (take && fermion.last_fermion) |=> (state_reg == S_CHECK))
        else $error("last fermion did not start the count check");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> (step_reg <= STEP_CMP))
        else $error("evaluation step out of range");

    a_counts_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        post |=> (jet_count_reg == 3'd0 && item_count_reg == 3'd0 && tau_count_reg == 3'd0))
        else $error("event counts not cleared after result");

endmodule
